@@ src/bxa_pkg.sv @@
// Shared types, field widths and event/result codes for the bus crossbar arbiter.
// No dependencies; used by every module of the block.
`default_nettype none

package bxa_pkg;

    // fixed field widths
    localparam int ACTION_W  = 3;
    localparam int INIT_W    = 2;
    localparam int TGT_W     = 3;
    localparam int DATA_W    = 8;
    localparam int ACK_W     = 2;
    localparam int KIND_W    = 3;
    localparam int PORT_W    = 3;
    localparam int PRESENT_W = 8;

    // results per request: stop, granted start, granted write, own start or ack
    localparam int MAX_RES = 4;
    localparam int CNT_W   = 3;
    localparam int IDX_W   = 2;

    // parameter defaults
    localparam int DEF_NUM_INITIATORS = 4;
    localparam int DEF_NUM_TARGETS    = 8;
    localparam int DEF_ADDR_WIDTH     = 24;

    localparam logic [PRESENT_W-1:0] PRESENT_RESET = 8'hFF;

    // bus event codes
    localparam logic [ACTION_W-1:0] ACT_ADDR  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_START = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_WDATA = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_TACK  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_TDATA = 3'd5;

    // result codes
    localparam logic [KIND_W-1:0] KIND_START = 3'd0;
    localparam logic [KIND_W-1:0] KIND_STOP  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

    localparam logic [ACK_W-1:0] ACK_NULL = 2'd0;

    // one bus event, address travels beside it
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [INIT_W-1:0]   initiator;
        logic [TGT_W-1:0]    target;
        logic                target_hit;
        logic                write_enable;
        logic [DATA_W-1:0]   data;
        logic [ACK_W-1:0]    ack_code;
    } ev_t;

    // one result, address travels beside it
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [PORT_W-1:0] port;
        logic              wr;
        logic [DATA_W-1:0] data;
        logic [ACK_W-1:0]  ack;
    } res_t;

    function automatic res_t mk_res(
        input logic [KIND_W-1:0] kind,
        input logic [PORT_W-1:0] port,
        input logic              wr,
        input logic [DATA_W-1:0] data,
        input logic [ACK_W-1:0]  ack
    );
        res_t r;
        r.kind = kind;
        r.port = port;
        r.wr   = wr;
        r.data = data;
        r.ack  = ack;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/bxa_event_core.sv @@
// Connection state of the crossbar and the per-request decision logic.
// Depends on bxa_pkg; builds the result list for the request in the input register.
`default_nettype none

module bxa_event_core #(
    parameter int NUM_INITIATORS = bxa_pkg::DEF_NUM_INITIATORS,
    parameter int NUM_TARGETS    = bxa_pkg::DEF_NUM_TARGETS,
    parameter int ADDR_WIDTH     = bxa_pkg::DEF_ADDR_WIDTH
) (
    input  wire logic                                           clk,
    input  wire logic                                           rst_n,
    input  wire logic                                           fire,
    input  wire bxa_pkg::ev_t                                   ev,
    input  wire logic [ADDR_WIDTH-1:0]                          ev_address,
    input  wire logic [bxa_pkg::PRESENT_W-1:0]                  target_present,
    output bxa_pkg::res_t [bxa_pkg::MAX_RES-1:0]                res_list,
    output logic [bxa_pkg::MAX_RES-1:0][ADDR_WIDTH-1:0]         res_addr,
    output logic [bxa_pkg::CNT_W-1:0]                           res_cnt
);

    localparam int IW = $clog2(NUM_INITIATORS);
    localparam int TW = $clog2(NUM_TARGETS);

    // per initiator
    logic [ADDR_WIDTH-1:0]         haddr_reg [NUM_INITIATORS];
    logic [ADDR_WIDTH-1:0]         haddr_next [NUM_INITIATORS];
    logic [bxa_pkg::TGT_W-1:0]     htgt_reg [NUM_INITIATORS];
    logic [bxa_pkg::TGT_W-1:0]     htgt_next [NUM_INITIATORS];
    logic [bxa_pkg::DATA_W-1:0]    hwd_reg [NUM_INITIATORS];
    logic [bxa_pkg::DATA_W-1:0]    hwd_next [NUM_INITIATORS];
    logic [NUM_INITIATORS-1:0]     hwr_reg, hwr_next;
    logic [NUM_INITIATORS-1:0]     hok_reg, hok_next;
    logic [NUM_INITIATORS-1:0]     conn_reg, conn_next;
    logic [NUM_INITIATORS-1:0]     pend_reg, pend_next;
    logic [NUM_INITIATORS-1:0]     wwait_reg, wwait_next;
    // per target
    logic [NUM_TARGETS-1:0]        busy_reg, busy_next;
    logic [bxa_pkg::INIT_W-1:0]    owner_reg [NUM_TARGETS];
    logic [bxa_pkg::INIT_W-1:0]    owner_next [NUM_TARGETS];

    logic [IW-1:0]                 ini_idx;
    logic [IW-1:0]                 j_idx;
    logic [TW-1:0]                 th_idx;
    logic [TW-1:0]                 rt_idx;
    logic [bxa_pkg::TGT_W-1:0]     th;
    logic                          ini_in;
    logic                          th_in;
    logic                          rt_in;
    logic                          found;
    logic [bxa_pkg::CNT_W-1:0]     n;

    always_comb
    begin
        haddr_next = haddr_reg;
        htgt_next  = htgt_reg;
        hwd_next   = hwd_reg;
        hwr_next   = hwr_reg;
        hok_next   = hok_reg;
        conn_next  = conn_reg;
        pend_next  = pend_reg;
        wwait_next = wwait_reg;
        busy_next  = busy_reg;
        owner_next = owner_reg;
        res_list   = '0;
        res_addr   = '0;
        n          = '0;
        found      = 1'b0;
        j_idx      = '0;

        ini_idx = IW'(ev.initiator);
        ini_in  = int'(ev.initiator) < NUM_INITIATORS;
        th      = htgt_reg[ini_idx];
        th_idx  = TW'(th);
        th_in   = int'(th) < NUM_TARGETS;
        rt_idx  = TW'(ev.target);
        rt_in   = int'(ev.target) < NUM_TARGETS;

        if (ev.action <= bxa_pkg::ACT_WDATA && ini_in)
        begin
            unique case (ev.action)
                bxa_pkg::ACT_ADDR:
                begin
                    // latch only while idle
                    if (!conn_reg[ini_idx] && !pend_reg[ini_idx])
                    begin
                        haddr_next[ini_idx] = ev_address;
                        hwr_next[ini_idx]   = ev.write_enable;
                        htgt_next[ini_idx]  = ev.target;
                        hok_next[ini_idx]   = ev.target_hit;
                    end
                end
                bxa_pkg::ACT_START, bxa_pkg::ACT_STOP:
                begin
                    if (ev.action == bxa_pkg::ACT_START)
                        wwait_next[ini_idx] = 1'b0;
                    pend_next[ini_idx] = 1'b0;
                    // drop old connection, hand the target to lowest pending
                    if (conn_reg[ini_idx])
                    begin
                        conn_next[ini_idx] = 1'b0;
                        if (th_in)
                        begin
                            res_list[n[bxa_pkg::IDX_W-1:0]] = bxa_pkg::mk_res(
                                bxa_pkg::KIND_STOP, th, 1'b0, '0, '0);
                            n = n + bxa_pkg::CNT_W'(1);
                            busy_next[th_idx] = 1'b0;
                            for (int k = 0; k < NUM_INITIATORS; k++)
                            begin
                                if (!found && pend_next[k] && htgt_reg[k] == th)
                                begin
                                    found = 1'b1;
                                    j_idx = IW'(k);
                                end
                            end
                            if (found)
                            begin
                                pend_next[j_idx]  = 1'b0;
                                conn_next[j_idx]  = 1'b1;
                                busy_next[th_idx] = 1'b1;
                                owner_next[th_idx] = bxa_pkg::INIT_W'(j_idx);
                                res_list[n[bxa_pkg::IDX_W-1:0]] = bxa_pkg::mk_res(
                                    bxa_pkg::KIND_START, th, hwr_reg[j_idx], '0, '0);
                                res_addr[n[bxa_pkg::IDX_W-1:0]] = haddr_reg[j_idx];
                                n = n + bxa_pkg::CNT_W'(1);
                                if (wwait_reg[j_idx])
                                begin
                                    res_list[n[bxa_pkg::IDX_W-1:0]] = bxa_pkg::mk_res(
                                        bxa_pkg::KIND_WRITE, th, 1'b0, hwd_reg[j_idx], '0);
                                    n = n + bxa_pkg::CNT_W'(1);
                                    wwait_next[j_idx] = 1'b0;
                                end
                            end
                        end
                    end
                    // new connection attempt on the latched target
                    if (ev.action == bxa_pkg::ACT_START)
                    begin
                        if (!hok_reg[ini_idx] || !th_in || !target_present[th])
                        begin
                            res_list[n[bxa_pkg::IDX_W-1:0]] = bxa_pkg::mk_res(
                                bxa_pkg::KIND_ACK, bxa_pkg::PORT_W'(ev.initiator),
                                1'b0, '0, bxa_pkg::ACK_NULL);
                            n = n + bxa_pkg::CNT_W'(1);
                        end
                        else if (busy_next[th_idx])
                            pend_next[ini_idx] = 1'b1;
                        else
                        begin
                            conn_next[ini_idx] = 1'b1;
                            busy_next[th_idx]  = 1'b1;
                            owner_next[th_idx] = ev.initiator;
                            res_list[n[bxa_pkg::IDX_W-1:0]] = bxa_pkg::mk_res(
                                bxa_pkg::KIND_START, th, hwr_reg[ini_idx], '0, '0);
                            res_addr[n[bxa_pkg::IDX_W-1:0]] = haddr_reg[ini_idx];
                            n = n + bxa_pkg::CNT_W'(1);
                        end
                    end
                end
                bxa_pkg::ACT_WDATA:
                begin
                    if (conn_reg[ini_idx] && th_in)
                    begin
                        res_list[n[bxa_pkg::IDX_W-1:0]] = bxa_pkg::mk_res(
                            bxa_pkg::KIND_WRITE, th, 1'b0, ev.data, '0);
                        n = n + bxa_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        hwd_next[ini_idx]   = ev.data;
                        wwait_next[ini_idx] = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if ((ev.action == bxa_pkg::ACT_TACK || ev.action == bxa_pkg::ACT_TDATA)
                 && rt_in && busy_reg[rt_idx])
        begin
            // route target response to the owning initiator
            if (ev.action == bxa_pkg::ACT_TACK)
                res_list[0] = bxa_pkg::mk_res(bxa_pkg::KIND_ACK,
                    bxa_pkg::PORT_W'(owner_reg[rt_idx]), 1'b0, '0, ev.ack_code);
            else
                res_list[0] = bxa_pkg::mk_res(bxa_pkg::KIND_READ,
                    bxa_pkg::PORT_W'(owner_reg[rt_idx]), 1'b0, ev.data, '0);
            n = bxa_pkg::CNT_W'(1);
        end

        res_cnt = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hok_reg   <= '0;
            conn_reg  <= '0;
            pend_reg  <= '0;
            wwait_reg <= '0;
            busy_reg  <= '0;
        end
        else if (fire)
        begin
            hok_reg   <= hok_next;
            conn_reg  <= conn_next;
            pend_reg  <= pend_next;
            wwait_reg <= wwait_next;
            busy_reg  <= busy_next;
        end
    end

    // payload, only read under a control bit
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            haddr_reg <= haddr_next;
            htgt_reg  <= htgt_next;
            hwd_reg   <= hwd_next;
            hwr_reg   <= hwr_next;
            owner_reg <= owner_next;
        end
    end

endmodule

`default_nettype wire

@@ src/bxa_result_drain.sv @@
// Result group register and output sequencer, one result per cycle while out_stall is low.
// Depends on bxa_pkg; fed by bxa_event_core through the top level.
`default_nettype none

module bxa_result_drain #(
    parameter int ADDR_WIDTH = bxa_pkg::DEF_ADDR_WIDTH
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       load,
    input  wire bxa_pkg::res_t [bxa_pkg::MAX_RES-1:0]       load_list,
    input  wire logic [bxa_pkg::MAX_RES-1:0][ADDR_WIDTH-1:0] load_addr,
    input  wire logic [bxa_pkg::CNT_W-1:0]                  load_cnt,
    input  wire logic                                       out_stall,
    output logic                                            grp_free,
    output logic                                            out_valid,
    output logic [bxa_pkg::KIND_W-1:0]                      kind,
    output logic [bxa_pkg::PORT_W-1:0]                      port,
    output logic [ADDR_WIDTH-1:0]                           address_out,
    output logic                                            write_out,
    output logic [bxa_pkg::DATA_W-1:0]                      data_out,
    output logic [bxa_pkg::ACK_W-1:0]                       ack_out,
    output logic                                            last
);

    bxa_pkg::res_t [bxa_pkg::MAX_RES-1:0]        list_reg;
    logic [bxa_pkg::MAX_RES-1:0][ADDR_WIDTH-1:0] addr_reg;
    logic [bxa_pkg::CNT_W-1:0]                   cnt_reg;
    logic [bxa_pkg::IDX_W-1:0]                   idx_reg;
    logic                                        vld_reg;
    logic                                        take;
    bxa_pkg::res_t                               cur;

    assign cur      = list_reg[idx_reg];
    assign last     = (bxa_pkg::CNT_W'(idx_reg) + bxa_pkg::CNT_W'(1)) == cnt_reg;
    assign take     = vld_reg && !out_stall;
    assign grp_free = !vld_reg || (take && last);

    assign out_valid   = vld_reg;
    assign kind        = cur.kind;
    assign port        = cur.port;
    assign write_out   = cur.wr;
    assign data_out    = cur.data;
    assign ack_out     = cur.ack;
    assign address_out = addr_reg[idx_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            idx_reg <= '0;
        end
        else if (load)
        begin
            vld_reg <= 1'b1;
            idx_reg <= '0;
        end
        else if (take && last)
            vld_reg <= 1'b0;
        else if (take)
            idx_reg <= idx_reg + bxa_pkg::IDX_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            list_reg <= load_list;
            addr_reg <= load_addr;
            cnt_reg  <= load_cnt;
        end
    end

endmodule

`default_nettype wire

@@ src/bus_crossbar_connect_arbiter.sv @@
// Top level of the bus crossbar arbiter: input register, present-mask register,
// decision core (bxa_event_core) and result sequencer (bxa_result_drain); uses bxa_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one bus event per request:
//   address phase, cycle start, cycle stop, write data, target ack or read data.
//   Output channel (out_valid / out_stall) gives the resulting target commands
//   and initiator responses one per cycle while out_stall is low; last marks
//   the final result of a request. A request may cause no result (address
//   phase, held write data, dropped responses) or up to four (stop, replayed
//   start and write, null ack). Throughput: one request per cycle when it
//   causes at most one result and out_stall is low; a request with several
//   results holds the result register until all are shown on the single
//   output port. The decision for a request is made combinationally from the
//   input register while the previous group still drains.
//   Configuration: cfg_data (target_present mask) is written when cfg_valid is
//   high; cfg_ready is always high. Write it only while the block is idle.
//   Reset: all connections, pending marks and held write data are cleared, all
//   targets free, target_present becomes all ones.
//   Stall: out_stall freezes the shown result; in_stall rises once the input
//   register holds a request whose results cannot yet enter the result register.
`default_nettype none

module bus_crossbar_connect_arbiter #(
    parameter int NUM_INITIATORS = bxa_pkg::DEF_NUM_INITIATORS,
    parameter int NUM_TARGETS    = bxa_pkg::DEF_NUM_TARGETS,
    parameter int ADDR_WIDTH     = bxa_pkg::DEF_ADDR_WIDTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bxa_pkg::PRESENT_W-1:0]     cfg_data,
    // bus events
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [bxa_pkg::ACTION_W-1:0]      action,
    input  wire logic [bxa_pkg::INIT_W-1:0]        initiator,
    input  wire logic [bxa_pkg::TGT_W-1:0]         target,
    input  wire logic                              target_hit,
    input  wire logic [ADDR_WIDTH-1:0]             address,
    input  wire logic                              write_enable,
    input  wire logic [bxa_pkg::DATA_W-1:0]        data,
    input  wire logic [bxa_pkg::ACK_W-1:0]         ack_code,
    // results
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [bxa_pkg::KIND_W-1:0]             kind,
    output logic [bxa_pkg::PORT_W-1:0]             port,
    output logic [ADDR_WIDTH-1:0]                  address_out,
    output logic                                   write_out,
    output logic [bxa_pkg::DATA_W-1:0]             data_out,
    output logic [bxa_pkg::ACK_W-1:0]              ack_out,
    output logic                                   last
);

    logic [bxa_pkg::PRESENT_W-1:0]                present_reg;
    logic                                         in_vld_reg;
    bxa_pkg::ev_t                                 ev_reg;
    logic [ADDR_WIDTH-1:0]                        addr_reg;
    logic                                         accept;
    logic                                         fire;
    logic                                         grp_free;
    bxa_pkg::res_t [bxa_pkg::MAX_RES-1:0]         res_list;
    logic [bxa_pkg::MAX_RES-1:0][ADDR_WIDTH-1:0]  res_addr;
    logic [bxa_pkg::CNT_W-1:0]                    res_cnt;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            present_reg <= bxa_pkg::PRESENT_RESET;
        else if (cfg_valid && cfg_ready)
            present_reg <= cfg_data;
    end

    // request in the input register is decided when its results have room,
    // or at once when it causes none
    assign fire     = in_vld_reg && (grp_free || res_cnt == '0);
    assign in_stall = in_vld_reg && !fire;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (accept)
            in_vld_reg <= 1'b1;
        else if (fire)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ev_reg.action       <= action;
            ev_reg.initiator    <= initiator;
            ev_reg.target       <= target;
            ev_reg.target_hit   <= target_hit;
            ev_reg.write_enable <= write_enable;
            ev_reg.data         <= data;
            ev_reg.ack_code     <= ack_code;
            addr_reg            <= address;
        end
    end

    bxa_event_core #(
        .NUM_INITIATORS (NUM_INITIATORS),
        .NUM_TARGETS    (NUM_TARGETS),
        .ADDR_WIDTH     (ADDR_WIDTH)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .ev             (ev_reg),
        .ev_address     (addr_reg),
        .target_present (present_reg),
        .res_list       (res_list),
        .res_addr       (res_addr),
        .res_cnt        (res_cnt)
    );

    bxa_result_drain #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_drain (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (fire && res_cnt != '0),
        .load_list   (res_list),
        .load_addr   (res_addr),
        .load_cnt    (res_cnt),
        .out_stall   (out_stall),
        .grp_free    (grp_free),
        .out_valid   (out_valid),
        .kind        (kind),
        .port        (port),
        .address_out (address_out),
        .write_out   (write_out),
        .data_out    (data_out),
        .ack_out     (ack_out),
        .last        (last)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb_bus_crossbar_connect_arbiter.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for bus_crossbar_connect_arbiter: predicts target commands and
// initiator responses per request and compares them in order. Depends on bxa_pkg and the RTL.
module tb_bus_crossbar_connect_arbiter;

    localparam int NUM_INI = bxa_pkg::DEF_NUM_INITIATORS;
    localparam int NUM_TGT = bxa_pkg::DEF_NUM_TARGETS;
    localparam int ADDR_W  = bxa_pkg::DEF_ADDR_WIDTH;

    // upper bound on the results one request may cause
    localparam int MAX_PER_REQ = 5;
    // idle wait after the last owed result, to let the pipe empty
    localparam int SETTLE_CYCLES = 8;
    // cycles without any request or result taken before the run is declared hung
    localparam int HANG_LIMIT = 1000;

    // event codes the block ignores
    localparam logic [bxa_pkg::ACTION_W-1:0] ACT_RSVD_A = 3'd6;
    localparam logic [bxa_pkg::ACTION_W-1:0] ACT_RSVD_B = 3'd7;

    typedef struct packed {
        logic [bxa_pkg::ACTION_W-1:0] action;
        logic [bxa_pkg::INIT_W-1:0]   initiator;
        logic [bxa_pkg::TGT_W-1:0]    target;
        logic                         hit;
        logic [ADDR_W-1:0]            addr;
        logic                         we;
        logic [bxa_pkg::DATA_W-1:0]   dat;
        logic [bxa_pkg::ACK_W-1:0]    ack;
    } bus_event_t;

    typedef struct packed {
        logic [bxa_pkg::KIND_W-1:0] kind;
        logic [bxa_pkg::PORT_W-1:0] port;
        logic [ADDR_W-1:0]          addr;
        logic                       wr;
        logic [bxa_pkg::DATA_W-1:0] dat;
        logic [bxa_pkg::ACK_W-1:0]  ack;
        logic                       last;
    } bus_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [bxa_pkg::PRESENT_W-1:0] cfg_value = '0;

    logic       in_valid = 1'b0;
    logic       in_stall;
    bus_event_t cur_req = '0;

    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [bxa_pkg::KIND_W-1:0] kind;
    logic [bxa_pkg::PORT_W-1:0] port;
    logic [ADDR_W-1:0]          address_out;
    logic                       write_out;
    logic [bxa_pkg::DATA_W-1:0] data_out;
    logic [bxa_pkg::ACK_W-1:0]  ack_out;
    logic                       last;

    always #5 clk = ~clk;

    bus_crossbar_connect_arbiter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_value),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (cur_req.action),
        .initiator    (cur_req.initiator),
        .target       (cur_req.target),
        .target_hit   (cur_req.hit),
        .address      (cur_req.addr),
        .write_enable (cur_req.we),
        .data         (cur_req.dat),
        .ack_code     (cur_req.ack),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .port         (port),
        .address_out  (address_out),
        .write_out    (write_out),
        .data_out     (data_out),
        .ack_out      (ack_out),
        .last         (last)
    );

    // ------------------------------------------------------------------
    // Crossbar predictor: its own copy of the link state and present mask
    // ------------------------------------------------------------------
    logic [bxa_pkg::PRESENT_W-1:0] present_mask = bxa_pkg::PRESENT_RESET;
    logic [ADDR_W-1:0]             lat_addr  [NUM_INI] = '{default: '0};
    logic                          lat_wr    [NUM_INI] = '{default: 1'b0};
    logic [bxa_pkg::TGT_W-1:0]     lat_tgt   [NUM_INI] = '{default: '0};
    logic                          lat_ok    [NUM_INI] = '{default: 1'b0};
    logic                          conn      [NUM_INI] = '{default: 1'b0};
    logic                          pend      [NUM_INI] = '{default: 1'b0};
    logic [bxa_pkg::DATA_W-1:0]    wbuf      [NUM_INI] = '{default: '0};
    logic                          wbuf_full [NUM_INI] = '{default: 1'b0};
    logic                          busy      [NUM_TGT] = '{default: 1'b0};
    logic [bxa_pkg::INIT_W-1:0]    owner     [NUM_TGT] = '{default: '0};

    bus_result_t step_out[$];          // results of the request being predicted
    bus_result_t expected_results[$];  // results still owed by the block
    bus_event_t  req_queue[$];         // requests not yet offered

    function automatic void emit(input logic [bxa_pkg::KIND_W-1:0] k, input int unsigned p,
                                 input logic [ADDR_W-1:0] a, input logic w,
                                 input logic [bxa_pkg::DATA_W-1:0] d,
                                 input logic [bxa_pkg::ACK_W-1:0] ak);
        bus_result_t r;
        if (step_out.size() >= MAX_PER_REQ)
            return;
        r.kind = k;
        r.port = p[bxa_pkg::PORT_W-1:0];
        r.addr = a;
        r.wr   = w;
        r.dat  = d;
        r.ack  = ak;
        r.last = 1'b0;
        step_out.push_back(r);
    endfunction

    // connect initiator i to target t and replay its start and any held write
    function automatic void grant_link(input int i, input int t);
        pend[i]  = 1'b0;
        conn[i]  = 1'b1;
        busy[t]  = 1'b1;
        owner[t] = i[bxa_pkg::INIT_W-1:0];
        emit(bxa_pkg::KIND_START, t, lat_addr[i], lat_wr[i], '0, bxa_pkg::ACK_NULL);
        if (wbuf_full[i]) begin
            emit(bxa_pkg::KIND_WRITE, t, '0, 1'b0, wbuf[i], bxa_pkg::ACK_NULL);
            wbuf_full[i] = 1'b0;
        end
    endfunction

    // drop initiator i's link; a freed target goes to its lowest pending initiator
    function automatic void drop_link(input int i);
        int t;
        pend[i] = 1'b0;
        if (conn[i]) begin
            t = int'(lat_tgt[i]);
            conn[i] = 1'b0;
            if (t < NUM_TGT) begin
                emit(bxa_pkg::KIND_STOP, t, '0, 1'b0, '0, bxa_pkg::ACK_NULL);
                busy[t] = 1'b0;
                for (int j = 0; j < NUM_INI; j++) begin
                    if (pend[j] && lat_tgt[j] == t) begin
                        grant_link(j, t);
                        break;
                    end
                end
            end
        end
    endfunction

    function automatic void crossbar_step(input bus_event_t ev);
        int i;
        int t;
        int n;
        bus_result_t r;
        i = int'(ev.initiator);
        t = int'(ev.target);
        step_out.delete();
        case (ev.action)
            bxa_pkg::ACT_ADDR: begin
                // address phase only lands on an idle initiator
                if (!conn[i] && !pend[i]) begin
                    lat_addr[i] = ev.addr;
                    lat_wr[i]   = ev.we;
                    lat_tgt[i]  = ev.target;
                    lat_ok[i]   = ev.hit;
                end
            end
            bxa_pkg::ACT_START: begin
                wbuf_full[i] = 1'b0;
                drop_link(i);
                t = int'(lat_tgt[i]);
                conn[i] = 1'b0;
                pend[i] = 1'b0;
                if (!lat_ok[i] || t >= NUM_TGT || !present_mask[t])
                    emit(bxa_pkg::KIND_ACK, i, '0, 1'b0, '0, bxa_pkg::ACK_NULL);
                else if (busy[t])
                    pend[i] = 1'b1;
                else
                    grant_link(i, t);
            end
            bxa_pkg::ACT_STOP: drop_link(i);
            bxa_pkg::ACT_WDATA: begin
                if (conn[i] && lat_tgt[i] < NUM_TGT) begin
                    emit(bxa_pkg::KIND_WRITE, int'(lat_tgt[i]), '0, 1'b0, ev.dat,
                         bxa_pkg::ACK_NULL);
                end else begin
                    wbuf[i]      = ev.dat;
                    wbuf_full[i] = 1'b1;
                end
            end
            bxa_pkg::ACT_TACK: begin
                if (t < NUM_TGT && busy[t])
                    emit(bxa_pkg::KIND_ACK, int'(owner[t]), '0, 1'b0, '0, ev.ack);
            end
            bxa_pkg::ACT_TDATA: begin
                if (t < NUM_TGT && busy[t])
                    emit(bxa_pkg::KIND_READ, int'(owner[t]), '0, 1'b0, ev.dat,
                         bxa_pkg::ACK_NULL);
            end
            default: ;
        endcase
        n = step_out.size();
        for (int k = 0; k < n; k++) begin
            r = step_out[k];
            r.last = (k == n - 1);
            expected_results.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Request driver: offers queued requests, predicts each one taken
    // ------------------------------------------------------------------
    bit idle_on = 1'b1;  // random gaps and stalls enabled
    int src_gap = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            src_gap  <= 0;
        end else begin
            if (in_valid && !in_stall)
                crossbar_step(cur_req);
            // a stalled request holds still; otherwise pick what comes next
            if (!in_valid || !in_stall) begin
                if (src_gap != 0) begin
                    src_gap  <= src_gap - 1;
                    in_valid <= 1'b0;
                end else if (req_queue.size() != 0) begin
                    cur_req  <= req_queue.pop_front();
                    in_valid <= 1'b1;
                    if (idle_on && $urandom_range(0, 7) == 0)
                        src_gap <= int'($urandom_range(1, 14));
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random stall bursts, in-order compare
    // ------------------------------------------------------------------
    int n_err = 0;
    int n_out = 0;
    int sink_gap = 0;

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        n_err++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want_v);
        if (got !== want_v)
            report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                      n_out, name, got, want_v));
    endtask

    always @(posedge clk or negedge rst_n) begin
        bus_result_t want;
        if (!rst_n) begin
            out_stall <= 1'b0;
            sink_gap  <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                n_out++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d kind %0d port %0d not expected",
                                              n_out, kind, port));
                end else begin
                    want = expected_results.pop_front();
                    compare_field("kind", 32'(kind), 32'(want.kind));
                    compare_field("port", 32'(port), 32'(want.port));
                    compare_field("address_out", 32'(address_out), 32'(want.addr));
                    compare_field("write_out", 32'(write_out), 32'(want.wr));
                    compare_field("data_out", 32'(data_out), 32'(want.dat));
                    compare_field("ack_out", 32'(ack_out), 32'(want.ack));
                    compare_field("last", 32'(last), 32'(want.last));
                end
            end
            if (sink_gap != 0) begin
                sink_gap  <= sink_gap - 1;
                out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                sink_gap  <= int'($urandom_range(0, 13));
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // hang detector: nothing taken on either side for too long
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == HANG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic void queue_req(input logic [bxa_pkg::ACTION_W-1:0] act, input int i,
                                      input int t, input logic h,
                                      input logic [ADDR_W-1:0] a, input logic w,
                                      input logic [bxa_pkg::DATA_W-1:0] d,
                                      input logic [bxa_pkg::ACK_W-1:0] ak);
        bus_event_t ev;
        ev.action    = act;
        ev.initiator = i[bxa_pkg::INIT_W-1:0];
        ev.target    = t[bxa_pkg::TGT_W-1:0];
        ev.hit       = h;
        ev.addr      = a;
        ev.we        = w;
        ev.dat       = d;
        ev.ack       = ak;
        req_queue.push_back(ev);
    endfunction

    function automatic bus_event_t rand_req();
        bus_event_t ev;
        ev.action    = bxa_pkg::ACTION_W'($urandom_range(0, 7));
        ev.initiator = bxa_pkg::INIT_W'($urandom_range(0, NUM_INI - 1));
        ev.target    = bxa_pkg::TGT_W'($urandom_range(0, NUM_TGT - 1));
        ev.hit       = 1'($urandom_range(0, 1));
        ev.addr      = ADDR_W'($urandom);
        ev.we        = 1'($urandom_range(0, 1));
        ev.dat       = bxa_pkg::DATA_W'($urandom);
        ev.ack       = bxa_pkg::ACK_W'($urandom_range(0, 3));
        return ev;
    endfunction

    // per-initiator progress of the generated bus cycles
    int gen_stage [NUM_INI] = '{default: 0};
    int gen_tgt   [NUM_INI] = '{default: 0};

    // mostly well-formed cycles (address, start, data/acks, stop) on random
    // initiators, sharing a few targets so that pending and grants happen
    task automatic gen_traffic(input int n);
        bus_event_t ev;
        int i;
        int c;
        for (int k = 0; k < n; k++) begin
            ev = rand_req();
            i  = int'(ev.initiator);
            c  = int'($urandom_range(0, 9));
            if ($urandom_range(0, 99) < 12) begin
                // noise: left fully random
            end else if (gen_stage[i] == 0) begin
                ev.action = bxa_pkg::ACT_ADDR;
                if ($urandom_range(0, 3) != 0)
                    ev.target = bxa_pkg::TGT_W'($urandom_range(0, 2));
                ev.hit = ($urandom_range(0, 15) != 0);
                gen_tgt[i] = int'(ev.target);
                gen_stage[i] = 1;
            end else if (gen_stage[i] == 1) begin
                if (c < 2) begin
                    ev.action = bxa_pkg::ACT_WDATA;     // early data, dropped by the start
                end else if (c == 2) begin
                    ev.action = bxa_pkg::ACT_STOP;      // abandoned before start
                    gen_stage[i] = 0;
                end else begin
                    ev.action = bxa_pkg::ACT_START;
                    gen_stage[i] = 2;
                end
            end else begin
                if (c < 3) begin
                    ev.action = bxa_pkg::ACT_WDATA;
                end else if (c < 7) begin
                    ev.action = (c < 5) ? bxa_pkg::ACT_TACK : bxa_pkg::ACT_TDATA;
                    if ($urandom_range(0, 4) != 0)
                        ev.target = bxa_pkg::TGT_W'(gen_tgt[i]);
                end else if (c < 9) begin
                    ev.action = bxa_pkg::ACT_STOP;
                    gen_stage[i] = 0;
                end else begin
                    ev.action = bxa_pkg::ACT_START;     // restart without a stop
                end
            end
            req_queue.push_back(ev);
        end
    endtask

    // wait for the sender and all owed results, then let the pipe empty
    task automatic wait_idle();
        while (req_queue.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_present(input logic [bxa_pkg::PRESENT_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_value <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        present_mask = v;
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed requests, all targets present after reset
        @(negedge clk);
        queue_req(bxa_pkg::ACT_ADDR,  0, 0, 1'b1, 24'h000000, 1'b0, 8'h00, 2'd0);
        queue_req(bxa_pkg::ACT_WDATA, 0, 0, 1'b0, 24'h000000, 1'b0, 8'h00, 2'd0); // dropped by start
        queue_req(bxa_pkg::ACT_START, 0, 0, 1'b0, 24'h000000, 1'b0, 8'h00, 2'd0);
        queue_req(bxa_pkg::ACT_WDATA, 0, 0, 1'b0, 24'h000000, 1'b0, 8'hFF, 2'd0);
        queue_req(bxa_pkg::ACT_TACK,  0, 0, 1'b0, 24'h000000, 1'b0, 8'h00, 2'd3);
        queue_req(bxa_pkg::ACT_TDATA, 0, 0, 1'b0, 24'h000000, 1'b0, 8'hFF, 2'd0);
        queue_req(bxa_pkg::ACT_ADDR,  0, 5, 1'b1, 24'h123456, 1'b1, 8'h00, 2'd0); // ignored
        queue_req(bxa_pkg::ACT_ADDR,  1, 0, 1'b1, 24'hFFFFFF, 1'b1, 8'h00, 2'd0);
        queue_req(bxa_pkg::ACT_START, 1, 0, 1'b0, 24'h000000, 1'b0, 8'h00, 2'd0); // pending
        queue_req(bxa_pkg::ACT_ADDR,  2, 0, 1'b1, 24'h800001, 1'b0, 8'h00, 2'd0);
        queue_req(bxa_pkg::ACT_START, 2, 0, 1'b0, 24'h000000, 1'b0, 8'h00, 2'd0);
        queue_req(bxa_pkg::ACT_WDATA, 1, 0, 1'b0, 24'h000000, 1'b0, 8'hAA, 2'd0); // held
        queue_req(bxa_pkg::ACT_STOP,  0, 0, 1'b0, 24'h000000, 1'b0, 8'h00, 2'd0); // grants lowest
        queue_req(bxa_pkg::ACT_STOP,  2, 0, 1'b0, 24'h000000, 1'b0, 8'h00, 2'd0); // clears pending
        queue_req(bxa_pkg::ACT_TACK,  0, 3, 1'b0, 24'h000000, 1'b0, 8'h00, 2'd1); // free target
        queue_req(bxa_pkg::ACT_TDATA, 0, 3, 1'b0, 24'h000000, 1'b0, 8'h5A, 2'd0);
        queue_req(bxa_pkg::ACT_ADDR,  3, 7, 1'b0, 24'hFFFFFF, 1'b0, 8'h00, 2'd0); // unmapped
        queue_req(bxa_pkg::ACT_START, 3, 0, 1'b0, 24'h000000, 1'b0, 8'h00, 2'd0);
        queue_req(bxa_pkg::ACT_STOP,  3, 0, 1'b0, 24'h000000, 1'b0, 8'h00, 2'd0); // idle stop
        queue_req(bxa_pkg::ACT_ADDR,  2, 0, 1'b1, 24'h00F0F0, 1'b1, 8'h00, 2'd0);
        queue_req(bxa_pkg::ACT_START, 2, 0, 1'b0, 24'h000000, 1'b0, 8'h00, 2'd0);
        queue_req(bxa_pkg::ACT_WDATA, 2, 0, 1'b0, 24'h000000, 1'b0, 8'h55, 2'd0);
        queue_req(bxa_pkg::ACT_ADDR,  3, 0, 1'b1, 24'hABCDEF, 1'b0, 8'h00, 2'd0);
        queue_req(bxa_pkg::ACT_START, 3, 0, 1'b0, 24'h000000, 1'b0, 8'h00, 2'd0);
        queue_req(ACT_RSVD_A, 0, 0, 1'b1, 24'hFFFFFF, 1'b1, 8'hFF, 2'd3);
        queue_req(ACT_RSVD_B, 3, 7, 1'b1, 24'hFFFFFF, 1'b1, 8'hFF, 2'd3);
        wait_idle();

        // no target present: restart of a linked initiator gives stop, replayed
        // start and write of the next one, then its own null ack
        write_present(8'h00);
        @(negedge clk);
        queue_req(bxa_pkg::ACT_START, 1, 0, 1'b0, 24'h000000, 1'b0, 8'h00, 2'd0);
        queue_req(bxa_pkg::ACT_STOP,  2, 0, 1'b0, 24'h000000, 1'b0, 8'h00, 2'd0);
        queue_req(bxa_pkg::ACT_ADDR,  0, 4, 1'b1, 24'h0F0F0F, 1'b1, 8'h00, 2'd0);
        queue_req(bxa_pkg::ACT_START, 0, 0, 1'b0, 24'h000000, 1'b0, 8'h00, 2'd0); // absent
        queue_req(bxa_pkg::ACT_STOP,  3, 0, 1'b0, 24'h000000, 1'b0, 8'h00, 2'd0);
        wait_idle();

        write_present(bxa_pkg::PRESENT_W'($urandom_range(1, 254)));
        @(negedge clk);
        gen_traffic(50);
        wait_idle();

        write_present(bxa_pkg::PRESENT_RESET);
        @(negedge clk);
        gen_traffic(40);
        wait_idle();

        // closing stretch at full rate on both sides
        @(negedge clk);
        idle_on <= 1'b0;
        gen_traffic(30);
        wait_idle();

        if (n_err == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
